>>> design/roll_pitch_kalman_filter_macros.svh
// ----------------------------------------------------------------------------
// Roll/pitch Kalman filter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROLL_PITCH_KALMAN_FILTER_MACROS_SVH
`define ROLL_PITCH_KALMAN_FILTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RPKF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RPKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rpkf_pkg.sv
// ----------------------------------------------------------------------------
// Roll/pitch Kalman filter package
// Types, operation codes and fixed constants shared by the filter modules.
// ----------------------------------------------------------------------------
package rpkf_pkg;

    // Angle and unit constants (angles are Q3.28 radians).
    localparam logic signed [31:0] ANGLE_HALF_PI = 32'sd421657428;
    localparam logic signed [23:0] DEG_SCALE     = 24'sd3754936;
    localparam int HALF_CIRCLE_DEG = 180;
    localparam int DEG_LIMIT       = HALF_CIRCLE_DEG * 128;
    localparam logic signed [20:0] DEG_LIMIT_W   = 21'(DEG_LIMIT);

    // Last iteration indexes of the square root and the gain divider.
    localparam logic [4:0] SQRT_LAST = 5'd23;
    localparam logic [4:0] DIV_LAST  = 5'd30;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_TIME_STEP      = 2'd0;
    localparam logic [1:0] CFG_GYRO_VARIANCE  = 2'd1;
    localparam logic [1:0] CFG_ACCEL_VARIANCE = 2'd2;
    localparam logic [15:0] TIME_STEP_RST      = 16'd655;
    localparam logic [31:0] GYRO_VARIANCE_RST  = 32'd16777;
    localparam logic [31:0] ACCEL_VARIANCE_RST = 32'd503316;

    // Datapath operations.
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP        = 5'd0;
    localparam t_op OP_SQ_AX      = 5'd1;
    localparam t_op OP_SQ_AZ      = 5'd2;
    localparam t_op OP_SQRT_INIT  = 5'd3;
    localparam t_op OP_SQRT_STEP  = 5'd4;
    localparam t_op OP_CORD_INIT  = 5'd5;
    localparam t_op OP_CORD_STEP  = 5'd6;
    localparam t_op OP_CORD_SAVE  = 5'd7;
    localparam t_op OP_PRED_MUL   = 5'd8;
    localparam t_op OP_PRED       = 5'd9;
    localparam t_op OP_DIV_INIT   = 5'd10;
    localparam t_op OP_DIV_STEP   = 5'd11;
    localparam t_op OP_DIFF       = 5'd12;
    localparam t_op OP_MUL_DLO    = 5'd13;
    localparam t_op OP_MUL_DHI    = 5'd14;
    localparam t_op OP_EST_SUM    = 5'd15;
    localparam t_op OP_EST        = 5'd16;
    localparam t_op OP_VAR_SUM    = 5'd17;
    localparam t_op OP_VAR        = 5'd18;
    localparam t_op OP_DEG_MUL    = 5'd19;
    localparam t_op OP_DEG        = 5'd20;
    localparam t_op OP_PUBLISH    = 5'd21;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic       load;
        t_op        op;
        logic       axis;
        logic [4:0] idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] roll_degrees;
        logic signed [15:0] pitch_degrees;
    } t_out_item;

    // CORDIC angle table, atan(2^-i) in Q3.28.
    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            5'd23: v = 32'sd32;
            5'd24: v = 32'sd16;
            5'd25: v = 32'sd8;
            5'd26: v = 32'sd4;
            5'd27: v = 32'sd2;
            5'd28: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/rpkf_in_if.sv
// ----------------------------------------------------------------------------
// Roll/pitch Kalman filter input channel
// Valid/ready channel carrying one IMU sample per transfer.
// ----------------------------------------------------------------------------
interface rpkf_in_if;
    logic               valid;
    logic               ready;
    rpkf_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/rpkf_out_if.sv
// ----------------------------------------------------------------------------
// Roll/pitch Kalman filter output channel
// Valid/ready channel carrying one pair of angle estimates per transfer.
// ----------------------------------------------------------------------------
interface rpkf_out_if;
    logic                valid;
    logic                ready;
    rpkf_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/rpkf_controller.sv
// ----------------------------------------------------------------------------
// Roll/pitch Kalman filter controller
// Sequences the datapath through square root, CORDIC and filter update steps.
// ----------------------------------------------------------------------------
module rpkf_controller #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rpkf_pkg::t_status i_status,
    output rpkf_pkg::t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SQ_AX     = 5'd1;
    localparam logic [4:0] S_SQ_AZ     = 5'd2;
    localparam logic [4:0] S_SQRT_INIT = 5'd3;
    localparam logic [4:0] S_SQRT      = 5'd4;
    localparam logic [4:0] S_CORD_INIT = 5'd5;
    localparam logic [4:0] S_CORD      = 5'd6;
    localparam logic [4:0] S_CORD_SAVE = 5'd7;
    localparam logic [4:0] S_PRED_MUL  = 5'd8;
    localparam logic [4:0] S_PRED      = 5'd9;
    localparam logic [4:0] S_DIV_INIT  = 5'd10;
    localparam logic [4:0] S_DIV       = 5'd11;
    localparam logic [4:0] S_DIFF      = 5'd12;
    localparam logic [4:0] S_MUL_DLO   = 5'd13;
    localparam logic [4:0] S_MUL_DHI   = 5'd14;
    localparam logic [4:0] S_EST_SUM   = 5'd15;
    localparam logic [4:0] S_EST       = 5'd16;
    localparam logic [4:0] S_VAR_SUM   = 5'd17;
    localparam logic [4:0] S_VAR       = 5'd18;
    localparam logic [4:0] S_DEG_MUL   = 5'd19;
    localparam logic [4:0] S_DEG       = 5'd20;
    localparam logic [4:0] S_PUBLISH   = 5'd21;

    localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);

    logic [4:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_axis, n_axis;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_axis     = r_axis;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_cmd.idx  = r_cnt;
        case (r_state)
            S_IDLE: begin
                // The input stays closed while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ_AX;
                end
            end
            S_SQ_AX: begin
                o_cmd.op = rpkf_pkg::OP_SQ_AX;
                n_state  = S_SQ_AZ;
            end
            S_SQ_AZ: begin
                o_cmd.op = rpkf_pkg::OP_SQ_AZ;
                n_state  = S_SQRT_INIT;
            end
            S_SQRT_INIT: begin
                o_cmd.op = rpkf_pkg::OP_SQRT_INIT;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = rpkf_pkg::OP_SQRT_STEP;
                if (r_cnt == rpkf_pkg::SQRT_LAST) begin
                    n_axis  = 1'b0;
                    n_state = S_CORD_INIT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_CORD_INIT: begin
                o_cmd.op = rpkf_pkg::OP_CORD_INIT;
                n_cnt    = '0;
                n_state  = S_CORD;
            end
            S_CORD: begin
                o_cmd.op = rpkf_pkg::OP_CORD_STEP;
                if (r_cnt == CORD_LAST) begin
                    n_state = S_CORD_SAVE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_CORD_SAVE: begin
                o_cmd.op = rpkf_pkg::OP_CORD_SAVE;
                n_axis   = ~r_axis;
                n_state  = r_axis ? S_PRED_MUL : S_CORD_INIT;
            end
            S_PRED_MUL: begin
                o_cmd.op = rpkf_pkg::OP_PRED_MUL;
                n_state  = S_PRED;
            end
            S_PRED: begin
                o_cmd.op = rpkf_pkg::OP_PRED;
                n_state  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.op = rpkf_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = rpkf_pkg::OP_DIV_STEP;
                if (r_cnt == rpkf_pkg::DIV_LAST) begin
                    n_state = S_DIFF;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DIFF: begin
                o_cmd.op = rpkf_pkg::OP_DIFF;
                n_state  = S_MUL_DLO;
            end
            S_MUL_DLO: begin
                o_cmd.op = rpkf_pkg::OP_MUL_DLO;
                n_state  = S_MUL_DHI;
            end
            S_MUL_DHI: begin
                o_cmd.op = rpkf_pkg::OP_MUL_DHI;
                n_state  = S_EST_SUM;
            end
            S_EST_SUM: begin
                o_cmd.op = rpkf_pkg::OP_EST_SUM;
                n_state  = S_EST;
            end
            S_EST: begin
                o_cmd.op = rpkf_pkg::OP_EST;
                n_state  = S_VAR_SUM;
            end
            S_VAR_SUM: begin
                o_cmd.op = rpkf_pkg::OP_VAR_SUM;
                n_state  = S_VAR;
            end
            S_VAR: begin
                o_cmd.op = rpkf_pkg::OP_VAR;
                n_state  = S_DEG_MUL;
            end
            S_DEG_MUL: begin
                o_cmd.op = rpkf_pkg::OP_DEG_MUL;
                n_state  = S_DEG;
            end
            S_DEG: begin
                o_cmd.op = rpkf_pkg::OP_DEG;
                n_axis   = ~r_axis;
                n_state  = r_axis ? S_PUBLISH : S_PRED_MUL;
            end
            S_PUBLISH: begin
                // Wait until the output register can take the new result.
                if (i_status.out_free) begin
                    o_cmd.op = rpkf_pkg::OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

endmodule

>>> design/rpkf_datapath.sv
// ----------------------------------------------------------------------------
// Roll/pitch Kalman filter datapath
// Shared multiplier, square root, CORDIC and divider steps, filter state and
// the output register.
// ----------------------------------------------------------------------------
module rpkf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpkf_pkg::t_cmd      i_cmd,
    output rpkf_pkg::t_status   o_status,
    input  rpkf_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output rpkf_pkg::t_out_item o_out_item
);

    localparam logic signed [35:0] PRED_MAX = 36'sd2147483647;
    localparam logic signed [35:0] PRED_MIN = -36'sd2147483648;
    localparam logic signed [57:0] DEG_HALF = 58'sd68719476736;

    // Configuration registers.
    logic [15:0] r_time_step;
    logic [31:0] r_gyro_var;
    logic [31:0] r_accel_var;

    // Filter state.
    logic signed [31:0] r_roll_est;
    logic signed [31:0] r_pitch_est;
    logic [31:0]        r_roll_var;
    logic [31:0]        r_pitch_var;

    // Captured sample.
    logic signed [15:0] r_gx, r_gy, r_ax, r_ay, r_az;

    // Working registers.
    logic signed [57:0] r_mul;
    logic signed [63:0] r_acc;
    logic [47:0]        r_sv, r_sres, r_sbit;
    logic signed [47:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic               r_czero;
    logic signed [31:0] r_zroll, r_zpitch;
    logic signed [31:0] r_pred;
    logic [31:0]        r_p;
    logic [32:0]        r_den;
    logic [33:0]        r_rem;
    logic [30:0]        r_k;
    logic signed [32:0] r_diff;
    logic signed [15:0] r_deg_roll, r_deg_pitch;
    logic               r_out_valid;
    rpkf_pkg::t_out_item r_out_item;

    // Combinational helpers.
    logic signed [33:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [63:0] mul64;
    logic signed [31:0] est_sel, zmeas_sel;
    logic [31:0]        var_sel;
    logic signed [15:0] rate_sel;
    logic signed [35:0] pred_sum;
    logic signed [31:0] pred_sat;
    logic [32:0]        p_sum;
    logic [31:0]        p_sat;
    logic [47:0]        sq_try;
    logic signed [25:0] cx0, cy0, cxp, cyp;
    logic signed [31:0] czp;
    logic signed [47:0] cdx, cdy;
    logic               div_q;
    logic [33:0]        rem_sub;
    logic signed [31:0] est_new;
    logic signed [57:0] deg_sum;
    logic signed [20:0] deg_q;
    logic signed [15:0] deg_sat;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

    // Per-axis selection.
    assign est_sel   = i_cmd.axis ? r_pitch_est : r_roll_est;
    assign var_sel   = i_cmd.axis ? r_pitch_var : r_roll_var;
    assign rate_sel  = i_cmd.axis ? r_gy : r_gx;
    assign zmeas_sel = i_cmd.axis ? r_zpitch : r_zroll;
    assign mul64     = 64'(r_mul);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            rpkf_pkg::OP_SQ_AX: begin
                mul_a = 34'(r_ax);
                mul_b = 24'(r_ax);
            end
            rpkf_pkg::OP_SQ_AZ: begin
                mul_a = 34'(r_az);
                mul_b = 24'(r_az);
            end
            rpkf_pkg::OP_PRED_MUL: begin
                mul_a = 34'(rate_sel);
                mul_b = {8'd0, r_time_step};
            end
            rpkf_pkg::OP_MUL_DLO: begin
                mul_a = 34'(r_diff);
                mul_b = {8'd0, r_k[15:0]};
            end
            rpkf_pkg::OP_MUL_DHI: begin
                mul_a = 34'(r_diff);
                mul_b = {9'd0, r_k[30:16]};
            end
            rpkf_pkg::OP_EST_SUM: begin
                mul_a = {2'b00, r_p};
                mul_b = {8'd0, r_k[15:0]};
            end
            rpkf_pkg::OP_EST: begin
                mul_a = {2'b00, r_p};
                mul_b = {9'd0, r_k[30:16]};
            end
            rpkf_pkg::OP_DEG_MUL: begin
                mul_a = 34'(est_sel);
                mul_b = rpkf_pkg::DEG_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Prediction: angle plus rate times step, variance plus process noise.
    always_comb begin
        pred_sum = 36'(est_sel) + 36'(signed'({r_mul[33:0], 2'b00}));
        if (pred_sum > PRED_MAX) begin
            pred_sat = 32'sh7FFF_FFFF;
        end else if (pred_sum < PRED_MIN) begin
            pred_sat = 32'sh8000_0000;
        end else begin
            pred_sat = pred_sum[31:0];
        end
        p_sum = {1'b0, var_sel} + {1'b0, r_gyro_var};
        p_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    end

    // CORDIC start vector with a quarter-turn pre-rotation for negative x.
    always_comb begin
        if (i_cmd.axis) begin
            cy0 = -(26'(r_ay) <<< 8);
            cx0 = {2'b00, r_sres[23:0]};
        end else begin
            cy0 = -26'(r_ax);
            cx0 = 26'(r_az);
        end
        if (cx0 < 0) begin
            if (cy0 >= 0) begin
                cxp = cy0;
                cyp = -cx0;
                czp = rpkf_pkg::ANGLE_HALF_PI;
            end else begin
                cxp = -cy0;
                cyp = cx0;
                czp = -rpkf_pkg::ANGLE_HALF_PI;
            end
        end else begin
            cxp = cx0;
            cyp = cy0;
            czp = '0;
        end
    end

    // One CORDIC rotation, one square root digit, one quotient bit.
    assign cdx     = r_cy >>> i_cmd.idx;
    assign cdy     = r_cx >>> i_cmd.idx;
    assign sq_try  = r_sres + r_sbit;
    assign div_q   = (r_den != '0) && (r_rem >= {1'b0, r_den});
    assign rem_sub = div_q ? (r_rem - {1'b0, r_den}) : r_rem;

    // Estimate update and conversion to degrees.
    assign est_new = 32'(34'(r_pred) + signed'(r_acc[63:30]));
    assign deg_sum = r_mul + DEG_HALF;
    assign deg_q   = signed'(deg_sum[57:37]);
    always_comb begin
        if (deg_q > rpkf_pkg::DEG_LIMIT_W) begin
            deg_sat = 16'(rpkf_pkg::DEG_LIMIT_W);
        end else if (deg_q < -rpkf_pkg::DEG_LIMIT_W) begin
            deg_sat = 16'(-rpkf_pkg::DEG_LIMIT_W);
        end else begin
            deg_sat = deg_q[15:0];
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_mul <= mul_a * mul_b;
        if (i_cmd.load) begin
            r_gx <= i_item.rate_x;
            r_gy <= i_item.rate_y;
            r_ax <= i_item.accel_x;
            r_ay <= i_item.accel_y;
            r_az <= i_item.accel_z;
        end
        case (i_cmd.op)
            rpkf_pkg::OP_SQ_AZ: begin
                r_acc <= mul64;
            end
            rpkf_pkg::OP_SQRT_INIT: begin
                r_sv   <= {r_acc[31:0] + r_mul[31:0], 16'd0};
                r_sres <= '0;
                r_sbit <= 48'd1 << 46;
            end
            rpkf_pkg::OP_SQRT_STEP: begin
                if (r_sv >= sq_try) begin
                    r_sv   <= r_sv - sq_try;
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            rpkf_pkg::OP_CORD_INIT: begin
                r_cx    <= 48'(cxp) <<< 20;
                r_cy    <= 48'(cyp) <<< 20;
                r_cz    <= czp;
                r_czero <= (cx0 == '0) && (cy0 == '0);
            end
            rpkf_pkg::OP_CORD_STEP: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + cdx;
                    r_cy <= r_cy - cdy;
                    r_cz <= r_cz + rpkf_pkg::atan_entry(i_cmd.idx);
                end else begin
                    r_cx <= r_cx - cdx;
                    r_cy <= r_cy + cdy;
                    r_cz <= r_cz - rpkf_pkg::atan_entry(i_cmd.idx);
                end
            end
            rpkf_pkg::OP_CORD_SAVE: begin
                // A zero accelerometer vector measures an angle of zero.
                if (i_cmd.axis) begin
                    r_zpitch <= r_czero ? 32'sd0 : r_cz;
                end else begin
                    r_zroll <= r_czero ? 32'sd0 : r_cz;
                end
            end
            rpkf_pkg::OP_PRED: begin
                r_pred <= pred_sat;
                r_p    <= p_sat;
            end
            rpkf_pkg::OP_DIV_INIT: begin
                r_den <= {1'b0, r_p} + {1'b0, r_accel_var};
                r_rem <= {2'b00, r_p};
                r_k   <= '0;
            end
            rpkf_pkg::OP_DIV_STEP: begin
                r_rem <= {rem_sub[32:0], 1'b0};
                r_k   <= {r_k[29:0], div_q};
            end
            rpkf_pkg::OP_DIFF: begin
                r_diff <= 33'(zmeas_sel) - 33'(r_pred);
            end
            rpkf_pkg::OP_MUL_DHI: begin
                r_acc <= mul64;
            end
            rpkf_pkg::OP_EST_SUM: begin
                r_acc <= r_acc + (mul64 <<< 16);
            end
            rpkf_pkg::OP_EST: begin
                r_acc <= mul64;
            end
            rpkf_pkg::OP_VAR_SUM: begin
                r_acc <= r_acc + (mul64 <<< 16);
            end
            rpkf_pkg::OP_DEG: begin
                if (i_cmd.axis) begin
                    r_deg_pitch <= deg_sat;
                end else begin
                    r_deg_roll <= deg_sat;
                end
            end
            rpkf_pkg::OP_PUBLISH: begin
                r_out_item.roll_degrees  <= r_deg_roll;
                r_out_item.pitch_degrees <= r_deg_pitch;
            end
            default: begin
            end
        endcase
    end

    // Configuration, filter state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= rpkf_pkg::TIME_STEP_RST;
            r_gyro_var  <= rpkf_pkg::GYRO_VARIANCE_RST;
            r_accel_var <= rpkf_pkg::ACCEL_VARIANCE_RST;
            r_roll_est  <= '0;
            r_pitch_est <= '0;
            r_roll_var  <= '0;
            r_pitch_var <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rpkf_pkg::CFG_TIME_STEP:      r_time_step <= i_cfg_data[15:0];
                    rpkf_pkg::CFG_GYRO_VARIANCE:  r_gyro_var  <= i_cfg_data;
                    rpkf_pkg::CFG_ACCEL_VARIANCE: r_accel_var <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == rpkf_pkg::OP_EST) begin
                if (i_cmd.axis) begin
                    r_pitch_est <= est_new;
                end else begin
                    r_roll_est <= est_new;
                end
            end
            if (i_cmd.op == rpkf_pkg::OP_VAR) begin
                if (i_cmd.axis) begin
                    r_pitch_var <= r_p - r_acc[61:30];
                end else begin
                    r_roll_var <= r_p - r_acc[61:30];
                end
            end
            if (i_cmd.op == rpkf_pkg::OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/roll_pitch_kalman_filter.sv
// ----------------------------------------------------------------------------
// Roll/pitch Kalman filter
// Scalar Kalman filter per axis fusing gyro rates with accelerometer angles.
//
//   Channel   Direction  Transfer
//   i_in      in         one IMU sample: gyro rates and accelerations
//   o_out     out        roll and pitch in degrees, Q8.7
//   i_cfg_*   in         register write: time step, gyro and accel variance
//
// A sample passes the serial square root, the CORDIC run once per axis and the
// one-bit-a-cycle gain divider run once per axis before the next is accepted.
// Reset is synchronous and active low; it restores register defaults and
// clears estimates and variances. A finished result waits in the output
// register, and the next sample is taken meanwhile; only the result hand-over
// stalls while the previous result has not been taken.
// ----------------------------------------------------------------------------
`include "roll_pitch_kalman_filter_macros.svh"

module roll_pitch_kalman_filter #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpkf_in_if.sink     i_in,
    rpkf_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rpkf_pkg::t_cmd    cmd;
    rpkf_pkg::t_status status;

    // Sequencer.
    rpkf_controller #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic, state and output register.
    rpkf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_in.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.payload)
    );

    // An accepted sample closes the input until it has been processed.
    `RPKF_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "input ready after accept")
    // A result is handed over only into a free output register.
    `RPKF_ASSERT_NOW(a_publish_free, cmd.op == rpkf_pkg::OP_PUBLISH, status.out_free, "publish while output full")
    // Output valid comes up only from a hand-over.
    `RPKF_ASSERT_NOW(a_valid_from_publish, $rose(o_out.valid), $past(cmd.op == rpkf_pkg::OP_PUBLISH), "output valid without publish")

endmodule
